FILE: sv/sync_length_packet_deframer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sync/length packet deframer
// Checks compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_PACKET_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_PACKET_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only outside reset.
`define SLPD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("deframer check failed");
// Checked at every edge, reset included.
`define SLPD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("deframer check failed");
`else
`define SLPD_ASSERT(label, prop)
`define SLPD_ASSERT_ALWAYS(label, prop)
`endif

`endif

FILE: sv/slpd_pkg.sv
// ----------------------------------------------------------------------------
// Sync/length packet deframer package
// Types, operation codes, phase encoding and framing constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slpd_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] LEN_LIMIT = 8'd254;

  localparam logic [1:0] OP_BYTE       = 2'd0;
  localparam logic [1:0] OP_RELEASE    = 2'd1;
  localparam logic [1:0] OP_LINE_ERROR = 2'd2;

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_LEN   = 3'd2,
    PH_CMD   = 3'd3,
    PH_DATA  = 3'd4,
    PH_HOLD  = 3'd5
  } phase_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] frame_command;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic       payload_valid;
    logic       frame_end;
  } result_t;

endpackage

FILE: sv/sync_length_packet_deframer.sv
// ----------------------------------------------------------------------------
// Sync/length packet deframer
// Results are registered, in the output register or, while it is held, in the skid entry.
// One item is taken per cycle while the skid entry is empty; a two-entry output buffer
// (register + skid) lets input keep flowing while the result side stalls, until the skid fills.
// Reset (synchronous, active high) returns to sync hunting with empty outputs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sync_length_packet_deframer_defines.svh"

module sync_length_packet_deframer (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  slpd_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output slpd_pkg::result_t result
);

  slpd_pkg::phase_t  phase;
  slpd_pkg::phase_t  phase_next;
  logic [7:0]        bytes_remaining;
  logic [7:0]        bytes_remaining_next;
  logic [7:0]        current_command;
  logic [7:0]        current_command_next;
  logic [7:0]        payload_position;
  logic [7:0]        payload_position_next;

  logic              skid_valid;
  slpd_pkg::result_t skid;
  slpd_pkg::result_t res_new;
  logic              res_push;
  logic              accept;
  logic              pop;
  logic [7:0]        rem_dec;

  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign pop        = result_valid && !result_stall;
  assign rem_dec    = bytes_remaining - 8'd1;

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (accept) begin
      case (item.operation)
        slpd_pkg::OP_LINE_ERROR: phase_next = slpd_pkg::PH_SYNC1;
        slpd_pkg::OP_RELEASE: begin
          if (phase == slpd_pkg::PH_HOLD) begin
            phase_next = slpd_pkg::PH_SYNC1;
          end
        end
        slpd_pkg::OP_BYTE: begin
          case (phase)
            slpd_pkg::PH_SYNC2: begin
              phase_next = (item.rx_byte == slpd_pkg::SYNC_BYTE) ?
                           slpd_pkg::PH_LEN : slpd_pkg::PH_SYNC1;
            end
            slpd_pkg::PH_LEN: begin
              phase_next = (item.rx_byte != 8'd0 && item.rx_byte < slpd_pkg::LEN_LIMIT) ?
                           slpd_pkg::PH_CMD : slpd_pkg::PH_SYNC1;
            end
            slpd_pkg::PH_CMD: begin
              phase_next = (rem_dec != 8'd0) ? slpd_pkg::PH_DATA : slpd_pkg::PH_HOLD;
            end
            slpd_pkg::PH_DATA: begin
              phase_next = (rem_dec != 8'd0) ? slpd_pkg::PH_DATA : slpd_pkg::PH_HOLD;
            end
            slpd_pkg::PH_HOLD: phase_next = slpd_pkg::PH_HOLD;
            default: begin
              phase_next = (item.rx_byte == slpd_pkg::SYNC_BYTE) ?
                           slpd_pkg::PH_SYNC2 : slpd_pkg::PH_SYNC1;
            end
          endcase
        end
        default: phase_next = phase;
      endcase
    end
  end

  // Counters, command and the result of this item.
  always_comb begin
    bytes_remaining_next  = bytes_remaining;
    current_command_next  = current_command;
    payload_position_next = payload_position;
    res_push              = 1'b0;
    res_new               = '0;
    if (accept && item.operation == slpd_pkg::OP_BYTE) begin
      case (phase)
        slpd_pkg::PH_LEN: begin
          if (item.rx_byte != 8'd0 && item.rx_byte < slpd_pkg::LEN_LIMIT) begin
            bytes_remaining_next = item.rx_byte;
          end
        end
        slpd_pkg::PH_CMD: begin
          current_command_next  = item.rx_byte;
          bytes_remaining_next  = rem_dec;
          payload_position_next = 8'd0;
          if (rem_dec == 8'd0) begin
            // A length of one closes the frame on the command byte.
            res_push              = 1'b1;
            res_new.frame_command = item.rx_byte;
            res_new.frame_end     = 1'b1;
          end
        end
        slpd_pkg::PH_DATA: begin
          bytes_remaining_next  = rem_dec;
          payload_position_next = payload_position + 8'd1;
          res_push              = 1'b1;
          res_new.frame_command = current_command;
          res_new.payload_byte  = item.rx_byte;
          res_new.byte_index    = payload_position;
          res_new.payload_valid = 1'b1;
          res_new.frame_end     = (rem_dec == 8'd0);
        end
        default: begin
          res_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= slpd_pkg::PH_SYNC1;
      bytes_remaining  <= 8'd0;
      current_command  <= 8'd0;
      payload_position <= 8'd0;
    end else begin
      phase            <= phase_next;
      bytes_remaining  <= bytes_remaining_next;
      current_command  <= current_command_next;
      payload_position <= payload_position_next;
    end
  end

  // Output register with a skid entry behind it. A push never coincides
  // with a full skid, since the input is stalled then.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= res_push;
      end
    end else if (res_push) begin
      if (!result_valid) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        result <= skid;
      end else if (res_push) begin
        result <= res_new;
      end
    end else if (res_push) begin
      if (!result_valid) begin
        result <= res_new;
      end else begin
        skid <= res_new;
      end
    end
  end

  `SLPD_ASSERT_ALWAYS(a_skid_behind_output, skid_valid |-> result_valid)
  `SLPD_ASSERT(a_skid_only_on_stall, $rose(skid_valid) |-> $past(result_valid && result_stall))
  `SLPD_ASSERT(a_data_has_bytes, phase == slpd_pkg::PH_DATA |-> bytes_remaining != 8'd0)
  `SLPD_ASSERT(a_end_enters_hold, (res_push && res_new.frame_end) |=> phase == slpd_pkg::PH_HOLD)
  `SLPD_ASSERT(a_push_needs_accept, res_push |-> (accept && item.operation == slpd_pkg::OP_BYTE))

endmodule
